/* rtl/core/hsl_color_range_key_mask_assert.svh */
// Assertion macros for the HSL key mask block.
`ifndef HSL_COLOR_RANGE_KEY_MASK_ASSERT_SVH
`define HSL_COLOR_RANGE_KEY_MASK_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define HKM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define HKM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/hkm_pkg.sv */
// ----------------------------------------------------------------------------
// hkm_pkg
// Types and constants shared by the HSL key mask block.
// ----------------------------------------------------------------------------
package hkm_pkg;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 50;

    localparam logic [CFG_IDX_W-1:0] REG_TOL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRIM  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXT_A = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXT_B = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EXT_C = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EXT_D = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OUT   = 3'd7;

    localparam logic [15:0] W_R = 16'd13933;
    localparam logic [15:0] W_G = 16'd46871;
    localparam logic [15:0] W_B = 16'd4732;
endpackage

/* rtl/core/hsl_color_range_key_mask.sv */
// ----------------------------------------------------------------------------
// hsl_color_range_key_mask
// HSL color-range soft key: one RGB pixel in, one Q0.16 mask value out.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse i_start with a pixel on i_red/i_green/i_blue while o_busy is low.
//   o_busy is tied low: a pixel may enter on every clock.
//   Each pixel leaves as one transaction on o_mask_value marked by o_strobe,
//   held for exactly one cycle; the receiver cannot stall the block.
//   The pipeline holds the hue/saturation dividers (18 stages), the square root
//   (19 stages), the smoothstep dividers (18 stages) and 9 single glue stages;
//   throughput is one pixel per clock, set by the fully pipelined units.
//   Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data;
//   o_cfg_ready is always high; write only while no pixel is in flight.
//   Synchronous active-low reset clears all valid bits and loads register
//   defaults; in-flight pixels are dropped.
// ----------------------------------------------------------------------------
module hsl_color_range_key_mask
    import hkm_pkg::*;
#(
    parameter int EXTRA_TARGETS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [15:0]           i_red,
    input  logic [15:0]           i_green,
    input  logic [15:0]           i_blue,
    output logic                  o_strobe,
    output logic [15:0]           o_mask_value,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int NT = 5;
    localparam int ONE = 65536;

    // ---------------- configuration ----------------
    logic [15:0] r_tol, r_soft;
    logic [47:0] r_prim;
    logic [49:0] r_ext [4];
    logic [16:0] r_outc;

    assign o_cfg_ready = 1'b1;
    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol  <= 16'd11796;
            r_soft <= 16'd7864;
            r_prim <= 48'd140740280057856;
            for (int k = 0; k < 4; k++) r_ext[k] <= '0;
            r_outc <= 17'd65535;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TOL:   r_tol    <= i_cfg_data[15:0];
                REG_SOFT:  r_soft   <= i_cfg_data[15:0];
                REG_PRIM:  r_prim   <= i_cfg_data[47:0];
                REG_EXT_A: r_ext[0] <= i_cfg_data;
                REG_EXT_B: r_ext[1] <= i_cfg_data;
                REG_EXT_C: r_ext[2] <= i_cfg_data;
                REG_EXT_D: r_ext[3] <= i_cfg_data;
                REG_OUT:   r_outc   <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    logic [15:0] tol, soft_eff;
    assign tol      = (r_tol  < 16'd66) ? 16'd66 : r_tol;
    assign soft_eff = (r_soft < 16'd66) ? 16'd66 : r_soft;

    logic [47:0] tgt [NT];
    logic [NT-1:0] en, sub;
    always_comb begin
        tgt[0] = r_prim; en[0] = 1'b1; sub[0] = 1'b0;
        for (int k = 0; k < 4; k++) begin
            tgt[k+1] = r_ext[k][47:0];
            en[k+1]  = (k < EXTRA_TARGETS) && r_ext[k][48];
            sub[k+1] = r_ext[k][49];
        end
    end

    // ---------------- stage A: min/max, luma products ----------------
    logic        r_a_v;
    logic [15:0] r_a_r, r_a_g, r_a_b, r_a_mx, r_a_mn;
    logic [1:0]  r_a_sec;
    logic [31:0] r_a_pr, r_a_pg, r_a_pb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_v <= 1'b0;
        else          r_a_v <= i_start;
    end

    always_ff @(posedge i_clk) begin
        logic [15:0] mx, mn;
        mx = i_red; mn = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue  > mx) mx = i_blue;
        if (i_green < mn) mn = i_green;
        if (i_blue  < mn) mn = i_blue;
        r_a_r  <= i_red; r_a_g <= i_green; r_a_b <= i_blue;
        r_a_mx <= mx; r_a_mn <= mn;
        priority if (mx == i_red)   r_a_sec <= 2'd0;
        else if (mx == i_green)     r_a_sec <= 2'd1;
        else                        r_a_sec <= 2'd2;
        r_a_pr <= i_red   * W_R;
        r_a_pg <= i_green * W_G;
        r_a_pb <= i_blue  * W_B;
    end

    // ---------------- stage B: numerators, denominators, luma ----------------
    logic        r_b_v, r_b_flat;
    logic [18:0] r_b_hnum, r_b_hden;
    logic [16:0] r_b_snum, r_b_sden;
    logic        r_b_szero;
    logic [15:0] r_b_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_v <= 1'b0;
        else          r_b_v <= r_a_v;
    end

    always_ff @(posedge i_clk) begin
        logic [16:0] dl, sm, dn;
        logic signed [19:0] t;
        logic [18:0] d6;
        logic [33:0] ys;
        dl = 17'(r_a_mx) - 17'(r_a_mn);
        sm = 17'(r_a_mx) + 17'(r_a_mn);
        dn = (sm < 17'(ONE)) ? sm : 17'(18'(2*ONE) - 18'(sm));
        d6 = 19'(dl) * 19'd6;
        unique case (r_a_sec)
            2'd0:    t = 20'(signed'({4'b0, r_a_g})) - 20'(signed'({4'b0, r_a_b}));
            2'd1:    t = 20'(signed'({3'b0, dl})) * 20'sd2
                         + 20'(signed'({4'b0, r_a_b})) - 20'(signed'({4'b0, r_a_r}));
            default: t = 20'(signed'({3'b0, dl})) * 20'sd4
                         + 20'(signed'({4'b0, r_a_r})) - 20'(signed'({4'b0, r_a_g}));
        endcase
        if (t < 0) t = t + 20'(signed'({1'b0, d6}));
        ys = 34'(r_a_pr) + 34'(r_a_pg) + 34'(r_a_pb) + 34'd32768;
        r_b_flat  <= dl <= 17'd0;
        r_b_hnum  <= 19'(t);
        r_b_hden  <= (dl == 0) ? 19'd1 : d6;
        r_b_snum  <= dl;
        r_b_sden  <= (dn == 0) ? 17'd1 : dn;
        r_b_szero <= (dn == 0);
        r_b_y     <= 16'(ys >> 16);
    end

    // ---------------- hue and saturation dividers ----------------
    logic        hv, sv;
    logic [16:0] hq, sq;
    logic [17:0] hside, sside_unused;

    hkm_divider #(.FB(16), .NW(19), .DW(19), .QW(17), .SW(18)) u_hue_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_b_v),
        .i_num(r_b_hnum), .i_den(r_b_hden),
        .i_side({r_b_flat, r_b_szero, r_b_y}),
        .o_valid(hv), .o_quot(hq), .o_side(hside)
    );

    hkm_divider #(.FB(16), .NW(17), .DW(17), .QW(17), .SW(18)) u_sat_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_b_v),
        .i_num(r_b_snum), .i_den(r_b_sden), .i_side(18'd0),
        .o_valid(sv), .o_quot(sq), .o_side(sside_unused)
    );

    // ---------------- stage C: HSL settle, squared distances ----------------
    logic        r_c_v;
    logic [35:0] r_c_d2 [NT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_v <= 1'b0;
        else          r_c_v <= hv;
    end

    always_ff @(posedge i_clk) begin
        logic [16:0] h, s, y, dh, ds, dy;
        logic [33:0] pdh, pds, pdy;
        logic flat;
        flat = hside[17];
        h = flat ? 17'd0 : {1'b0, hq[15:0]};
        if (flat) s = 17'd0;
        else if (hside[16]) s = 17'(ONE);
        else s = (sq > 17'(ONE)) ? 17'(ONE) : sq;
        y = {1'b0, hside[15:0]};
        for (int k = 0; k < NT; k++) begin
            dh = (h > {1'b0, tgt[k][15:0]}) ? h - {1'b0, tgt[k][15:0]}
                                             : {1'b0, tgt[k][15:0]} - h;
            ds = (s > {1'b0, tgt[k][31:16]}) ? s - {1'b0, tgt[k][31:16]}
                                              : {1'b0, tgt[k][31:16]} - s;
            dy = (y > {1'b0, tgt[k][47:32]}) ? y - {1'b0, tgt[k][47:32]}
                                              : {1'b0, tgt[k][47:32]} - y;
            if (dh > 17'(ONE)) dh = 17'(ONE);
            if (17'(ONE) - dh < dh) dh = 17'(ONE) - dh;
            pdh = dh * dh;
            pds = ds * ds;
            pdy = dy * dy;
            r_c_d2[k] <= {pdh, 2'b00} + 36'(pds) + 36'(pdy);
        end
    end

    // ---------------- pipelined integer square root ----------------
    localparam int SQ = 18;
    logic [SQ:0]  r_q_v;
    logic [35:0]  r_q_rem [NT][SQ+1];
    logic [35:0]  r_q_res [NT][SQ+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_q_v <= '0;
        else          r_q_v <= {r_q_v[SQ-1:0], r_c_v};
    end

    for (genvar k = 0; k < NT; k++) begin : g_sqrt
        always_ff @(posedge i_clk) begin
            r_q_rem[k][0] <= r_c_d2[k];
            r_q_res[k][0] <= '0;
        end
        for (genvar j = 0; j < SQ; j++) begin : g_bit
            localparam logic [35:0] BIT = 36'd1 << (2*(SQ-1-j));
            always_ff @(posedge i_clk) begin
                if (r_q_rem[k][j] >= r_q_res[k][j] + BIT) begin
                    r_q_rem[k][j+1] <= r_q_rem[k][j] - (r_q_res[k][j] + BIT);
                    r_q_res[k][j+1] <= (r_q_res[k][j] >> 1) + BIT;
                end else begin
                    r_q_rem[k][j+1] <= r_q_rem[k][j];
                    r_q_res[k][j+1] <= r_q_res[k][j] >> 1;
                end
            end
        end
    end

    // ---------------- stage D: distance minus tolerance ----------------
    logic        r_d_v;
    logic [17:0] r_d_num [NT];
    logic [NT-1:0] r_d_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d_v <= 1'b0;
        else          r_d_v <= r_q_v[SQ];
    end

    always_ff @(posedge i_clk) begin
        logic [17:0] d;
        for (int k = 0; k < NT; k++) begin
            d = r_q_res[k][SQ][17:0];
            r_d_zero[k] <= d <= {2'b0, tol};
            r_d_num[k]  <= (d > {2'b0, tol}) ? d - {2'b0, tol} : 18'd0;
        end
    end

    // ---------------- smoothstep dividers ----------------
    logic [NT-1:0] tv;
    logic [16:0]   tq [NT];
    logic [0:0]    tside [NT];

    for (genvar k = 0; k < NT; k++) begin : g_tdiv
        hkm_divider #(.FB(16), .NW(18), .DW(16), .QW(17), .SW(1)) u_t_div (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_d_v),
            .i_num(r_d_num[k]), .i_den(soft_eff), .i_side(r_d_zero[k]),
            .o_valid(tv[k]), .o_quot(tq[k]), .o_side(tside[k])
        );
    end

    // Quotient can exceed 17 bits: flag overflow by comparing numerator to softness.
    logic [17:0] r_ov_pipe [NT][18];
    for (genvar k = 0; k < NT; k++) begin : g_ov
        always_ff @(posedge i_clk) begin
            r_ov_pipe[k][0] <= {17'd0, (r_d_num[k] >= {2'b0, soft_eff})};
            for (int j = 1; j < 18; j++) r_ov_pipe[k][j] <= r_ov_pipe[k][j-1];
        end
    end

    // ---------------- stage E: clamp t, t^2 ----------------
    logic        r_e_v;
    logic [16:0] r_e_t [NT];
    logic [16:0] r_e_t2 [NT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e_v <= 1'b0;
        else          r_e_v <= tv[0];
    end

    always_ff @(posedge i_clk) begin
        logic [16:0] t;
        for (int k = 0; k < NT; k++) begin
            if (tside[k][0]) t = 17'd0;
            else if (r_ov_pipe[k][17][0] || tq[k] > 17'(ONE)) t = 17'(ONE);
            else t = tq[k];
            r_e_t[k]  <= t;
            r_e_t2[k] <= 17'((34'(t) * 34'(t) + 34'd32768) >> 16);
        end
    end

    // ---------------- stage F: smoothstep, sample ----------------
    logic        r_f_v;
    logic [16:0] r_f_smp [NT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_f_v <= 1'b0;
        else          r_f_v <= r_e_v;
    end

    always_ff @(posedge i_clk) begin
        logic [18:0] w;
        logic [35:0] p;
        logic [16:0] ss;
        for (int k = 0; k < NT; k++) begin
            w  = 19'(3*ONE) - 19'({r_e_t[k], 1'b0});
            p  = (36'(r_e_t2[k]) * 36'(w) + 36'd32768) >> 16;
            ss = (p > 36'(ONE)) ? 17'(ONE) : 17'(p);
            r_f_smp[k] <= 17'(ONE) - ss;
        end
    end

    // ---------------- stage G: combine ----------------
    logic        r_g_v;
    logic [16:0] r_g_pos, r_g_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_g_v <= 1'b0;
        else          r_g_v <= r_f_v;
    end

    always_ff @(posedge i_clk) begin
        logic [16:0] p, n;
        p = r_f_smp[0]; n = '0;
        for (int k = 1; k < NT; k++) begin
            if (en[k]) begin
                if (sub[k]) begin
                    if (r_f_smp[k] > n) n = r_f_smp[k];
                end else if (r_f_smp[k] > p) begin
                    p = r_f_smp[k];
                end
            end
        end
        r_g_pos <= p; r_g_neg <= n;
    end

    // ---------------- stage H: P*(1-N), invert ----------------
    logic        r_h_v;
    logic [16:0] r_h_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_h_v <= 1'b0;
        else          r_h_v <= r_g_v;
    end

    always_ff @(posedge i_clk) begin
        logic [33:0] p;
        logic [16:0] v;
        p = (34'(r_g_pos) * 34'(17'(ONE) - r_g_neg) + 34'd32768) >> 16;
        v = (p > 34'(ONE)) ? 17'(ONE) : 17'(p);
        r_h_val <= r_outc[16] ? 17'(ONE) - v : v;
    end

    // ---------------- stage I: opacity, saturate ----------------
    logic        r_i_v;
    logic [15:0] r_i_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_i_v <= 1'b0;
        else          r_i_v <= r_h_v;
    end

    always_ff @(posedge i_clk) begin
        logic [33:0] p;
        p = (34'(r_h_val) * 34'(r_outc[15:0]) + 34'd32768) >> 16;
        r_i_mask <= (p > 34'hFFFF) ? 16'hFFFF : p[15:0];
    end

    assign o_strobe     = r_i_v;
    assign o_mask_value = r_i_mask;

    logic unused_sig;
    assign unused_sig = sv ^ (|sside_unused) ^ (|tv[NT-1:1]);
endmodule

/* rtl/core/hkm_divider.sv */
// ----------------------------------------------------------------------------
// hkm_divider
// Pipelined restoring divider: quotient = floor(num * 2^FB / den), one
// quotient bit per stage, with a valid bit and a side-band word carried along.
// ----------------------------------------------------------------------------
module hkm_divider
    import hkm_pkg::*;
#(
    parameter int FB = 16,
    parameter int NW = 20,
    parameter int DW = 20,
    parameter int QW = 17,
    parameter int SW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quot,
    output logic [SW-1:0] o_side
);
    localparam int RW = DW + 1;
    localparam int XW = NW + FB;

    logic [QW:0]         r_vld;
    logic [RW-1:0]       r_rem  [QW+1];
    logic [XW-1:0]       r_dvd  [QW+1];
    logic [DW-1:0]       r_den  [QW+1];
    logic [QW-1:0]       r_quot [QW+1];
    logic [SW-1:0]       r_side [QW+1];

    // Dividend bits above the quotient width are folded in first.
    localparam int HI = XW - QW;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[QW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        logic [XW-1:0] dvd;
        dvd = XW'(i_num) << FB;
        r_rem[0]  <= RW'(dvd >> QW);
        r_dvd[0]  <= dvd;
        r_den[0]  <= i_den;
        r_quot[0] <= '0;
        r_side[0] <= i_side;
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [RW:0] trial;
        logic        ge;
        assign trial = {r_rem[k][RW-1:0], r_dvd[k][QW-1-k]};
        assign ge = trial >= {1'b0, 1'b0, r_den[k]};
        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= ge ? RW'(trial - {2'b00, r_den[k]}) : RW'(trial);
            r_dvd[k+1]  <= r_dvd[k];
            r_den[k+1]  <= r_den[k];
            r_quot[k+1] <= {r_quot[k][QW-2:0], ge};
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_valid = r_vld[QW];
    assign o_quot  = r_quot[QW];
    assign o_side  = r_side[QW];

    logic unused_hi;
    assign unused_hi = (HI > 0);
endmodule

/* rtl/core/hkm_checker.sv */
// ----------------------------------------------------------------------------
// hkm_checker
// Port-level checks for the HSL key mask block.
// ----------------------------------------------------------------------------
`include "hsl_color_range_key_mask_assert.svh"

module hkm_checker
    import hkm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_strobe,
    input logic [15:0] o_mask_value,
    input logic        o_cfg_ready
);
    `HKM_ASSERT_IMPL(a_never_busy, i_clk, i_rst_n, 1'b1, !o_busy)
    `HKM_ASSERT_IMPL(a_cfg_ready, i_clk, i_rst_n, 1'b1, o_cfg_ready)
    `HKM_ASSERT_NEXT(a_reset_quiet, i_clk, 1'b1, !i_rst_n, !o_strobe)
    `HKM_ASSERT_IMPL(a_no_x_mask, i_clk, i_rst_n, o_strobe, !$isunknown(o_mask_value))
endmodule

bind hsl_color_range_key_mask hkm_checker u_hkm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_strobe(o_strobe), .o_mask_value(o_mask_value), .o_cfg_ready(o_cfg_ready)
);
